### rtl/core/assert_macros.svh
// assertion macros shared by the core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// condition holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, cond)
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/core/bpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;

    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;
    localparam int DIV_W       = 32;
    localparam int SIDE_W      = 64;

    localparam logic [31:0] B6_OFFSET = 32'd4000;
    localparam logic [31:0] P_C1      = 32'd3038;
    localparam logic [31:0] P_C2      = 32'hFFFF_E343; // -7357
    localparam logic [31:0] P_C3      = 32'd3791;
    localparam logic [31:0] B7_SCALE  = 32'd50000;
    localparam logic [31:0] B4_BIAS   = 32'd32768;
    localparam logic [19:0] PA_MAX    = 20'hF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AC1,
        REG_AC2,
        REG_AC3,
        REG_AC4,
        REG_AC5_AC6,
        REG_B1_B2,
        REG_MC_MD,
        REG_OSS
    } cfg_reg_e;

    typedef struct packed {
        logic [15:0] ac1;
        logic [15:0] ac2;
        logic [15:0] ac3;
        logic [15:0] ac4;
        logic [15:0] ac5;
        logic [15:0] ac6;
        logic [15:0] b1;
        logic [15:0] b2;
        logic [15:0] mc;
        logic [15:0] md;
        logic [1:0]  oss;
    } cfg_t;

    typedef struct packed {
        logic [15:0] ut;
        logic [23:0] up;
    } item_t;

endpackage
`default_nettype wire

### rtl/core/bpc_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
interface bpc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;
    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface bpc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] temperature_tenths;
    logic        [19:0] pressure_pa;
    logic               divide_fault;
    modport source (output valid, output temperature_tenths, output pressure_pa,
                    output divide_fault, input ready);
    modport sink (input valid, input temperature_tenths, input pressure_pa,
                  input divide_fault, output ready);
endinterface

interface bpc_cfg_if import bpc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/bpc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module bpc_front
    import bpc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    bpc_cfg_if.sink   cfg,
    bpc_in_if.sink    samples,
    output cfg_t      cfg_q,
    output logic      push_valid,
    output item_t     push_item,
    input  wire logic push_ready
);

    cfg_t  cfg_reg;
    logic  fr_valid_reg;
    item_t fr_item_reg;
    item_t fr_item_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg     <= '0;
            cfg_reg.oss <= 2'd1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_e'(cfg.index))
                REG_AC1:     cfg_reg.ac1 <= cfg.data[15:0];
                REG_AC2:     cfg_reg.ac2 <= cfg.data[15:0];
                REG_AC3:     cfg_reg.ac3 <= cfg.data[15:0];
                REG_AC4:     cfg_reg.ac4 <= cfg.data[15:0];
                REG_AC5_AC6:
                begin
                    cfg_reg.ac5 <= cfg.data[31:16];
                    cfg_reg.ac6 <= cfg.data[15:0];
                end
                REG_B1_B2:
                begin
                    cfg_reg.b1 <= cfg.data[31:16];
                    cfg_reg.b2 <= cfg.data[15:0];
                end
                REG_MC_MD:
                begin
                    cfg_reg.mc <= cfg.data[31:16];
                    cfg_reg.md <= cfg.data[15:0];
                end
                REG_OSS:     cfg_reg.oss <= cfg.data[1:0];
            endcase
        end
    end

    // raw pressure aligned by the oversampling mode
    always_comb
    begin
        fr_item_next.ut = samples.raw_temperature;
        fr_item_next.up = samples.raw_pressure >> (4'd8 - {2'b00, cfg_reg.oss});
    end

    assign samples.ready = !fr_valid_reg || push_ready;
    assign push_valid    = fr_valid_reg;
    assign push_item     = fr_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fr_valid_reg <= 1'b0;
        else if (samples.ready)
            fr_valid_reg <= samples.valid;
    end

    always_ff @(posedge clk)
    begin
        if (samples.ready && samples.valid)
            fr_item_reg <= fr_item_next;
    end

endmodule
`default_nettype wire

### rtl/core/bpc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bpc_queue
    import bpc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push_valid,
    input  wire item_t push_item,
    output logic       push_ready,
    output logic       pop_valid,
    output item_t      pop_item,
    input  wire logic  pop_ready
);

    item_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              push_fire;
    logic              pop_fire;

    assign push_ready = cnt_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_item   = mem[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push_fire)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop_fire)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push_fire && !pop_fire)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop_fire && !push_fire)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
            mem[wr_ptr_reg] <= push_item;
    end

    `ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= QCNT_W'(QUEUE_DEPTH))
    `ASSERT_NEXT(a_cnt_up, push_fire && !pop_fire, cnt_reg == $past(cnt_reg) + 1'b1)
    `ASSERT_NEXT(a_ptr_gap, pop_fire && !push_fire, rd_ptr_reg == $past(rd_ptr_reg) + 1'b1)

endmodule
`default_nettype wire

### rtl/core/bpc_div.sv
`timescale 1ns / 1ps
`default_nettype none
module bpc_div
    import bpc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [DIV_W-1:0]  dividend,
    input  wire logic [DIV_W-1:0]  divisor,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_valid,
    output logic [DIV_W-1:0]       quotient,
    output logic [SIDE_W-1:0]      side_out
);

    // one quotient bit per stage, restoring
    logic              v_reg    [DIV_W];
    logic [DIV_W-1:0]  rem_reg  [DIV_W];
    logic [DIV_W-1:0]  quo_reg  [DIV_W];
    logic [DIV_W-1:0]  dvs_reg  [DIV_W];
    logic [SIDE_W-1:0] side_reg [DIV_W];

    for (genvar g = 0; g < DIV_W; g++)
    begin : g_stage
        logic              v_in;
        logic [DIV_W-1:0]  rem_in;
        logic [DIV_W-1:0]  quo_in;
        logic [DIV_W-1:0]  dvs_in;
        logic [SIDE_W-1:0] side_w;
        logic [DIV_W:0]    trial;
        logic [DIV_W-1:0]  rem_next;
        logic [DIV_W-1:0]  quo_next;

        if (g == 0)
        begin : g_first
            assign v_in   = in_valid;
            assign rem_in = '0;
            assign quo_in = dividend;
            assign dvs_in = divisor;
            assign side_w = side_in;
        end
        else
        begin : g_rest
            assign v_in   = v_reg[g-1];
            assign rem_in = rem_reg[g-1];
            assign quo_in = quo_reg[g-1];
            assign dvs_in = dvs_reg[g-1];
            assign side_w = side_reg[g-1];
        end

        assign trial = {rem_in, quo_in[DIV_W-1]} - {1'b0, dvs_in};

        always_comb
        begin
            if (!trial[DIV_W])
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_in[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_in[DIV_W-2:0], quo_in[DIV_W-1]};
                quo_next = {quo_in[DIV_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[g] <= 1'b0;
            else if (en)
                v_reg[g] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= rem_next;
                quo_reg[g]  <= quo_next;
                dvs_reg[g]  <= dvs_in;
                side_reg[g] <= side_w;
            end
        end
    end

    assign out_valid = v_reg[DIV_W-1];
    assign quotient  = quo_reg[DIV_W-1];
    assign side_out  = side_reg[DIV_W-1];

endmodule
`default_nettype wire

### rtl/core/bpc_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bpc_back
    import bpc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg_q,
    input  wire logic  pop_valid,
    input  wire item_t pop_item,
    output logic       pop_ready,
    bpc_out_if.source  results
);

    logic en;

    // sign-extended calibration words
    logic [31:0] ac1_x, ac2_x, ac3_x, b1_x, b2_x, md_x;
    assign ac1_x = {{16{cfg_q.ac1[15]}}, cfg_q.ac1};
    assign ac2_x = {{16{cfg_q.ac2[15]}}, cfg_q.ac2};
    assign ac3_x = {{16{cfg_q.ac3[15]}}, cfg_q.ac3};
    assign b1_x  = {{16{cfg_q.b1[15]}}, cfg_q.b1};
    assign b2_x  = {{16{cfg_q.b2[15]}}, cfg_q.b2};
    assign md_x  = {{16{cfg_q.md[15]}}, cfg_q.md};

    logic              s1_valid_reg;
    logic [31:0]       s1_prod_reg;
    logic [23:0]       s1_up_reg;
    logic [31:0]       s1_diff;
    logic [31:0]       s1_prod_next;

    logic [31:0]       s2_x1, s2_den, s2_num, s2_num_abs, s2_den_abs;
    logic              s2_fault, s2_qneg;
    logic [SIDE_W-1:0] s2_side;

    logic              d1_valid;
    logic [31:0]       d1_quo;
    logic [SIDE_W-1:0] d1_side;

    logic [31:0]       s3_x1, s3_x2, s3_b5, s3_t, s3_b6;
    logic [23:0]       s3_up;
    logic              s3_fault;
    logic              s3_qneg;
    logic [15:0]       s3_tsat;
    logic [31:0]       s3_b6sq_next, s3_ac2b6_next, s3_ac3b6_next;

    logic              s3_valid_reg, s3_fault_reg;
    logic [15:0]       s3_tsat_reg;
    logic [23:0]       s3_up_reg;
    logic [31:0]       s3_b6sq_reg, s3_ac2b6_reg, s3_ac3b6_reg;

    logic [31:0]       s4_sq;
    logic [31:0]       s4_b2sq_next, s4_b1sq_next;
    logic              s4_valid_reg, s4_fault_reg;
    logic [15:0]       s4_tsat_reg;
    logic [23:0]       s4_up_reg;
    logic [31:0]       s4_b2sq_reg, s4_b1sq_reg, s4_x2a_reg, s4_x1c_reg;

    logic [31:0]       s5_x3, s5_v, s5_b3_next, s5_x3b, s5_y_next;
    logic              s5_valid_reg, s5_fault_reg;
    logic [15:0]       s5_tsat_reg;
    logic [23:0]       s5_up_reg;
    logic [31:0]       s5_b3_reg, s5_y_reg;

    logic [31:0]       s6_b4prod_next, s6_b7_next;
    logic              s6_valid_reg, s6_fault_reg;
    logic [15:0]       s6_tsat_reg;
    logic [31:0]       s6_b4prod_reg, s6_b7_reg;

    logic [31:0]       s7_b4, s7_dividend;
    logic              s7_fault;
    logic [SIDE_W-1:0] s7_side;

    logic              d2_valid;
    logic [31:0]       d2_quo;
    logic [SIDE_W-1:0] d2_side;

    logic [31:0]       s8_p, s8_a, s8_m1_next, s8_m3_next;
    logic              s8_valid_reg, s8_fault_reg;
    logic [15:0]       s8_tsat_reg;
    logic [31:0]       s8_p_reg, s8_m1_reg, s8_m3_reg;

    logic [31:0]       s9_m2_next;
    logic              s9_valid_reg, s9_fault_reg;
    logic [15:0]       s9_tsat_reg;
    logic [31:0]       s9_p_reg, s9_m2_reg, s9_m3_reg;

    logic [31:0]       f_sum, f_p;
    logic [19:0]       f_pa;

    logic              out_valid_reg, out_fault_reg;
    logic [15:0]       out_temp_reg;
    logic [19:0]       out_pa_reg;

    // whole back pipeline moves unless the output slot is held
    assign en        = !out_valid_reg || results.ready;
    assign pop_ready = en;

    // raw temperature offset and scale
    assign s1_diff      = {16'd0, pop_item.ut} - {16'd0, cfg_q.ac6};
    assign s1_prod_next = s1_diff * {16'd0, cfg_q.ac5};

    // temperature divisor setup, sign-magnitude into the divider
    assign s2_x1      = $unsigned($signed(s1_prod_reg) >>> 15);
    assign s2_den     = s2_x1 + md_x;
    assign s2_num     = {{5{cfg_q.mc[15]}}, cfg_q.mc, 11'd0};
    assign s2_num_abs = s2_num[31] ? (32'd0 - s2_num) : s2_num;
    assign s2_den_abs = s2_den[31] ? (32'd0 - s2_den) : s2_den;
    assign s2_qneg    = s2_num[31] ^ s2_den[31];
    assign s2_fault   = s2_den == 32'd0;
    assign s2_side    = {6'd0, s2_x1, s1_up_reg, s2_fault, s2_qneg};

    bpc_div u_div_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid_reg),
        .dividend  (s2_num_abs),
        .divisor   (s2_den_abs),
        .side_in   (s2_side),
        .out_valid (d1_valid),
        .quotient  (d1_quo),
        .side_out  (d1_side)
    );

    // true temperature and b6 products
    assign s3_x1    = d1_side[57:26];
    assign s3_up    = d1_side[25:2];
    assign s3_fault = d1_side[1];
    assign s3_qneg  = d1_side[0];
    assign s3_x2    = s3_qneg ? (32'd0 - d1_quo) : d1_quo;
    assign s3_b5    = s3_x1 + s3_x2;
    assign s3_t     = $unsigned($signed(s3_b5 + 32'd8) >>> 4);
    assign s3_b6    = s3_b5 - B6_OFFSET;

    always_comb
    begin
        if ($signed(s3_t) > 32'sd32767)
            s3_tsat = 16'h7FFF;
        else if ($signed(s3_t) < -32'sd32768)
            s3_tsat = 16'h8000;
        else
            s3_tsat = s3_t[15:0];
    end

    assign s3_b6sq_next  = s3_b6 * s3_b6;
    assign s3_ac2b6_next = ac2_x * s3_b6;
    assign s3_ac3b6_next = ac3_x * s3_b6;

    assign s4_sq        = $unsigned($signed(s3_b6sq_reg) >>> 12);
    assign s4_b2sq_next = b2_x * s4_sq;
    assign s4_b1sq_next = b1_x * s4_sq;

    // b3 with a truncating divide by four, and the b4 bias
    assign s5_x3  = $unsigned($signed(s4_b2sq_reg) >>> 11) + s4_x2a_reg;
    assign s5_v   = (((ac1_x << 2) + s5_x3) << cfg_q.oss) + 32'd2;
    assign s5_b3_next = $unsigned($signed(s5_v + (s5_v[31] ? 32'd3 : 32'd0)) >>> 2);
    assign s5_x3b = $unsigned($signed(s4_x1c_reg
                    + $unsigned($signed(s4_b1sq_reg) >>> 16) + 32'd2) >>> 2);
    assign s5_y_next = s5_x3b + B4_BIAS;

    assign s6_b4prod_next = {16'd0, cfg_q.ac4} * s5_y_reg;
    assign s6_b7_next     = ({8'd0, s5_up_reg} - s5_b3_reg) * (B7_SCALE >> cfg_q.oss);

    // pressure divide: b7 doubled before or after by its top bit
    assign s7_b4       = {15'd0, s6_b4prod_reg[31:15]};
    assign s7_fault    = s6_fault_reg || (s7_b4 == 32'd0);
    assign s7_dividend = s6_b7_reg[31] ? s6_b7_reg : {s6_b7_reg[30:0], 1'b0};
    assign s7_side     = {46'd0, s6_tsat_reg, s7_fault, s6_b7_reg[31]};

    bpc_div u_div_p (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s6_valid_reg),
        .dividend  (s7_dividend),
        .divisor   (s7_b4),
        .side_in   (s7_side),
        .out_valid (d2_valid),
        .quotient  (d2_quo),
        .side_out  (d2_side)
    );

    assign s8_p       = d2_side[0] ? {d2_quo[30:0], 1'b0} : d2_quo;
    assign s8_a       = $unsigned($signed(s8_p) >>> 8);
    assign s8_m1_next = s8_a * s8_a;
    assign s8_m3_next = P_C2 * s8_p;

    assign s9_m2_next = s8_m1_reg * P_C1;

    assign f_sum = $unsigned($signed(s9_m2_reg) >>> 16)
                 + $unsigned($signed(s9_m3_reg) >>> 16) + P_C3;
    assign f_p   = s9_p_reg + $unsigned($signed(f_sum) >>> 4);

    always_comb
    begin
        if (f_p[31])
            f_pa = 20'd0;
        else if (f_p[30:20] != 11'd0)
            f_pa = PA_MAX;
        else
            f_pa = f_p[19:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            s9_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= pop_valid;
            s3_valid_reg  <= d1_valid;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            s8_valid_reg  <= d2_valid;
            s9_valid_reg  <= s8_valid_reg;
            out_valid_reg <= s9_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_prod_reg   <= s1_prod_next;
            s1_up_reg     <= pop_item.up;

            s3_fault_reg  <= s3_fault;
            s3_tsat_reg   <= s3_tsat;
            s3_up_reg     <= s3_up;
            s3_b6sq_reg   <= s3_b6sq_next;
            s3_ac2b6_reg  <= s3_ac2b6_next;
            s3_ac3b6_reg  <= s3_ac3b6_next;

            s4_fault_reg  <= s3_fault_reg;
            s4_tsat_reg   <= s3_tsat_reg;
            s4_up_reg     <= s3_up_reg;
            s4_b2sq_reg   <= s4_b2sq_next;
            s4_b1sq_reg   <= s4_b1sq_next;
            s4_x2a_reg    <= $unsigned($signed(s3_ac2b6_reg) >>> 11);
            s4_x1c_reg    <= $unsigned($signed(s3_ac3b6_reg) >>> 13);

            s5_fault_reg  <= s4_fault_reg;
            s5_tsat_reg   <= s4_tsat_reg;
            s5_up_reg     <= s4_up_reg;
            s5_b3_reg     <= s5_b3_next;
            s5_y_reg      <= s5_y_next;

            s6_fault_reg  <= s5_fault_reg;
            s6_tsat_reg   <= s5_tsat_reg;
            s6_b4prod_reg <= s6_b4prod_next;
            s6_b7_reg     <= s6_b7_next;

            s8_fault_reg  <= d2_side[1];
            s8_tsat_reg   <= d2_side[17:2];
            s8_p_reg      <= s8_p;
            s8_m1_reg     <= s8_m1_next;
            s8_m3_reg     <= s8_m3_next;

            s9_fault_reg  <= s8_fault_reg;
            s9_tsat_reg   <= s8_tsat_reg;
            s9_p_reg      <= s8_p_reg;
            s9_m2_reg     <= s9_m2_next;
            s9_m3_reg     <= s8_m3_reg;

            out_fault_reg <= s9_fault_reg;
            out_temp_reg  <= s9_fault_reg ? 16'd0 : s9_tsat_reg;
            out_pa_reg    <= s9_fault_reg ? 20'd0 : f_pa;
        end
    end

    assign results.valid              = out_valid_reg;
    assign results.temperature_tenths = $signed(out_temp_reg);
    assign results.pressure_pa        = out_pa_reg;
    assign results.divide_fault       = out_fault_reg;

    `ASSERT_IMPLIES(a_fault_zero, out_valid_reg && out_fault_reg, out_temp_reg == 16'd0 && out_pa_reg == 20'd0)
    `ASSERT_NEXT(a_out_load, en && s9_valid_reg, out_valid_reg)
    `ASSERT_NEXT(a_freeze, !en, $stable(s9_valid_reg) && $stable(s1_valid_reg))

endmodule
`default_nettype wire

### rtl/core/barometric_pressure_compensation_unit.sv
// barometric pressure compensation unit
// channels: samples carries one raw temperature word and one raw 24-bit
// pressure word per transfer; results carries the temperature in tenths of
// a degree, the pressure in pascals and a divide fault flag; cfg writes the
// calibration words and oversampling mode, one register per transfer
// throughput: one sample per cycle while results is drained
// path: from samples transfer to result valid a sample passes the front
// register, the queue, the two 32-stage pipelined dividers (temperature
// and pressure) and the stages around them
// reset: calibration words clear to zero, oversampling to standard mode,
// queue and pipelines empty
// stall: a held result freezes the back pipeline; the front keeps taking
// samples into a four-entry queue until it fills, then drops ready
`timescale 1ns / 1ps
`default_nettype none
module barometric_pressure_compensation_unit
    import bpc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    bpc_cfg_if.sink   cfg,
    bpc_in_if.sink    samples,
    bpc_out_if.source results
);

    // configuration snapshot shared by front and back
    cfg_t  cfg_q;

    // front to queue
    logic  push_valid;
    logic  push_ready;
    item_t push_item;

    // queue to back
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    // front: config registers, input transfer, pressure alignment
    bpc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .samples    (samples),
        .cfg_q      (cfg_q),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    // decoupling queue so each side stalls on its own
    bpc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    // back: compensation pipeline with output register
    bpc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_q     (cfg_q),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop_ready (pop_ready),
        .results   (results)
    );

endmodule
`default_nettype wire

### bench/barometric_pressure_compensation_unit_tb.sv
`timescale 1ns / 1ps
module barometric_pressure_compensation_unit_tb;
    import bpc_pkg::*;

    typedef struct packed {
        logic signed [15:0] temp;
        logic [19:0]        pa;
        logic               fault;
    } reading_t;

    // calibration state mirrored from the register writes
    typedef struct {
        logic [15:0] ac1, ac2, ac3, ac4;
        logic [31:0] ac56, b12, mcmd;
        logic [1:0]  oss;
    } calib_t;

    // arithmetic shift right on 32-bit words
    function automatic logic [31:0] sra32(logic [31:0] u, int k);
        return $unsigned($signed(u) >>> k);
    endfunction

    function automatic logic [31:0] sx16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // signed divide truncating toward zero
    function automatic logic [31:0] sdiv32(logic [31:0] a, logic [31:0] b);
        longint q;
        q = longint'($signed(a)) / longint'($signed(b));
        return q[31:0];
    endfunction

    // integer compensation of one raw reading pair
    function automatic reading_t compensate(calib_t c, logic [15:0] ut, logic [23:0] rp);
        reading_t r;
        logic [31:0] up, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, p, sq, den;
        longint t, pr;
        up  = {8'd0, rp} >> (8 - c.oss);
        ac1 = sx16(c.ac1);
        ac2 = sx16(c.ac2);
        ac3 = sx16(c.ac3);
        ac4 = {16'd0, c.ac4};
        ac5 = {16'd0, c.ac56[31:16]};
        ac6 = {16'd0, c.ac56[15:0]};
        b1  = sx16(c.b12[31:16]);
        b2  = sx16(c.b12[15:0]);
        mc  = sx16(c.mcmd[31:16]);
        md  = sx16(c.mcmd[15:0]);
        r = '{temp: 0, pa: 0, fault: 1'b1};
        x1 = sra32(({16'd0, ut} - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 0) return r;
        x2 = sdiv32(mc << 11, den);
        b5 = x1 + x2;
        t = longint'($signed(sra32(b5 + 32'd8, 4)));
        b6 = b5 - B6_OFFSET;
        sq = sra32(b6 * b6, 12);
        x1 = sra32(b2 * sq, 11);
        x2 = sra32(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = sdiv32(((ac1 * 32'd4 + x3) << c.oss) + 32'd2, 32'd4);
        x1 = sra32(ac3 * b6, 13);
        x2 = sra32(b1 * sq, 16);
        x3 = sra32(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + B4_BIAS)) >> 15;
        if (b4 == 0) return r;
        b7 = (up - b3) * (B7_SCALE >> c.oss);
        p = (b7 < 32'h8000_0000) ? (b7 << 1) / b4 : (b7 / b4) << 1;
        x1 = sra32(p, 8) * sra32(p, 8);
        x1 = sra32(x1 * P_C1, 16);
        x2 = sra32(P_C2 * p, 16);
        p = p + sra32(x1 + x2 + P_C3, 4);
        pr = longint'($signed(p));
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        if (pr < 0) pr = 0;
        if (pr > 1048575) pr = 1048575;
        r.temp = t[15:0];
        r.pa = pr[19:0];
        r.fault = 1'b0;
        return r;
    endfunction

    class reading_scoreboard;
        reading_t pending[$];
        int       mismatches;

        function void note_sample(calib_t c, logic [15:0] ut, logic [23:0] rp);
            pending.push_back(compensate(c, ut, rp));
        endfunction

        function void check_reading(reading_t got);
            reading_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (want.temp !== got.temp || want.pa !== got.pa || want.fault !== got.fault)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected t=%0d p=%0d f=%0b got t=%0d p=%0d f=%0b",
                             want.temp, want.pa, want.fault, got.temp, got.pa, got.fault);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #5 clk = ~clk;

    bpc_cfg_if cfg_ch();
    bpc_in_if  samp_ch();
    bpc_out_if res_ch();

    barometric_pressure_compensation_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch.sink),
        .samples (samp_ch.sink),
        .results (res_ch.source)
    );

    reading_scoreboard board = new();
    calib_t            calib;
    int                cycle_count = 0;
    int                hold_off = 0;     // cycles left in a forced receiver stall
    int                rx_gap = 0;       // cycles left in a random receiver gap
    bit                quiet_sink = 0;   // sink never idles while set
    localparam int     CYCLE_LIMIT = 2_000_000;

    initial
    begin
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        samp_ch.valid = 1'b0;
        samp_ch.raw_temperature = '0;
        samp_ch.raw_pressure = '0;
        res_ch.ready = 1'b0;
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[barometric_pressure_compensation_unit] ERROR");
            $finish;
        end
    end

    // result side: random ready, long stretches forced low on request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
                board.check_reading('{temp: res_ch.temperature_tenths,
                                      pa: res_ch.pressure_pa,
                                      fault: res_ch.divide_fault});
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                res_ch.ready <= 1'b0;
            end
            else if (quiet_sink)
                res_ch.ready <= 1'b1;
            else if (rx_gap > 0)
            begin
                rx_gap <= rx_gap - 1;
                res_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < 2)
            begin
                rx_gap <= $urandom_range(5, 40);
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(0, 99) < 70);
        end
    end

    // random gap length: mostly short, now and then long
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 92) return $urandom_range(0, 2);
        return $urandom_range(5, 40);
    endfunction

    task automatic write_reg(cfg_reg_e idx, logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_AC1:     calib.ac1 = value[15:0];
            REG_AC2:     calib.ac2 = value[15:0];
            REG_AC3:     calib.ac3 = value[15:0];
            REG_AC4:     calib.ac4 = value[15:0];
            REG_AC5_AC6: calib.ac56 = value;
            REG_B1_B2:   calib.b12 = value;
            REG_MC_MD:   calib.mcmd = value;
            REG_OSS:     calib.oss = value[1:0];
            default: ;
        endcase
    endtask

    // one sample transfer; gap first so valid is never dropped and raised in one step
    task automatic send_sample(logic [15:0] ut, logic [23:0] rp, bit idle);
        int g;
        g = idle ? gap_len() : 0;
        if (g > 0)
        begin
            samp_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        samp_ch.valid <= 1'b1;
        samp_ch.raw_temperature <= ut;
        samp_ch.raw_pressure <= rp;
        @(posedge clk);
        while (!samp_ch.ready) @(posedge clk);
        board.note_sample(calib, ut, rp);
    endtask

    // wait until every expected result is back, then let the pipe empty
    task automatic drain();
        samp_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // typical factory calibration with random jitter on every word, or fully random words when extreme is set
    task automatic load_calibration(bit extreme);
        if (extreme)
        begin
            write_reg(REG_AC1, $urandom());
            write_reg(REG_AC2, $urandom());
            write_reg(REG_AC3, $urandom());
            write_reg(REG_AC4, $urandom());
            write_reg(REG_AC5_AC6, $urandom());
            write_reg(REG_B1_B2, $urandom());
            write_reg(REG_MC_MD, $urandom());
        end
        else
        begin
            write_reg(REG_AC1, 32'd408 + $urandom_range(0, 8000));
            write_reg(REG_AC2, 32'hFFFF_FE00 + $urandom_range(0, 300));
            write_reg(REG_AC3, 32'hFFFF_C400 + $urandom_range(0, 200));
            write_reg(REG_AC4, 32'd30000 + $urandom_range(0, 5000));
            write_reg(REG_AC5_AC6, {16'd20000 + 16'($urandom_range(0, 20000)),
                                    16'd15000 + 16'($urandom_range(0, 20000))});
            write_reg(REG_B1_B2, {16'd6190 + 16'($urandom_range(0, 300)),
                                  16'($urandom_range(0, 100))});
            write_reg(REG_MC_MD, {16'hD4BD + 16'($urandom_range(0, 500)),
                                  16'd2000 + 16'($urandom_range(0, 1500))});
        end
    endtask

    logic [31:0] field_edges[4] = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_7FFF, 32'h8000_8000};

    initial
    begin
        int n;
        calib = '{ac1: 0, ac2: 0, ac3: 0, ac4: 0, ac56: 0, b12: 0, mcmd: 0, oss: 2'd1};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset calibration: every divisor is zero, so every result is a fault
        send_sample(16'h0000, 24'h000000, 0);
        send_sample(16'hFFFF, 24'hFFFFFF, 0);
        drain();

        // directed: typical calibration, field extremes in each mode
        load_calibration(0);
        for (int m = 0; m < 4; m++)
        begin
            write_reg(REG_OSS, m);
            send_sample(16'h0000, 24'h000000, 0);
            send_sample(16'hFFFF, 24'hFFFFFF, 0);
            send_sample(16'd27898, 24'h5D2300, 0);
            drain();
        end

        // zero temperature divisor: ut equal to ac6 with md zero
        write_reg(REG_MC_MD, 32'h1234_0000);
        send_sample(calib.ac56[15:0], 24'h800000, 0);
        drain();
        // zero pressure divisor: ac4 zero
        write_reg(REG_MC_MD, 32'hD4BD_0B00);
        write_reg(REG_AC4, 32'd0);
        send_sample(16'd27898, 24'h5D2300, 0);
        drain();

        // extreme calibration words with saturating results
        for (int e = 0; e < 4; e++)
        begin
            write_reg(REG_AC1, field_edges[e]);
            write_reg(REG_AC2, field_edges[(e + 1) % 4]);
            write_reg(REG_AC3, field_edges[(e + 2) % 4]);
            write_reg(REG_AC4, field_edges[(e + 3) % 4]);
            write_reg(REG_AC5_AC6, field_edges[e]);
            write_reg(REG_B1_B2, field_edges[(e + 1) % 4]);
            write_reg(REG_MC_MD, field_edges[(e + 2) % 4]);
            send_sample(16'h8000, 24'h800000, 0);
            send_sample(16'h7FFF, 24'h7FFFFF, 0);
            drain();
        end

        // random phases; most with realistic calibration, some with any words
        for (int ph = 0; ph < 12; ph++)
        begin
            load_calibration(ph % 4 == 3);
            write_reg(REG_OSS, $urandom_range(0, 3));
            n = 160;
            if (ph == 2)
            begin
                // long receiver stall while samples keep coming, so the queue fills
                hold_off = 300;
            end
            quiet_sink = (ph == 5);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 9) < 7)
                    send_sample(16'd20000 + 16'($urandom_range(0, 20000)),
                                24'($urandom_range(0, 24'hFFFFFF)), ph != 5);
                else
                    send_sample(16'($urandom()), 24'($urandom()), ph != 5);
            end
            drain();
        end
        quiet_sink = 0;

        repeat (100) @(posedge clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("[barometric_pressure_compensation_unit] OK");
        else
            $display("[barometric_pressure_compensation_unit] ERROR");
        $finish;
    end
endmodule

### sim.f
+incdir+rtl/core
rtl/core/bpc_pkg.sv
rtl/core/bpc_ifs.sv
rtl/core/bpc_front.sv
rtl/core/bpc_queue.sv
rtl/core/bpc_div.sv
rtl/core/bpc_back.sv
rtl/core/barometric_pressure_compensation_unit.sv
bench/barometric_pressure_compensation_unit_tb.sv
